>>> src/pheromone_matrix_update_macros.svh
// Assertion macros shared by the pheromone matrix update modules.
`ifndef PHEROMONE_MATRIX_UPDATE_MACROS_SVH
`define PHEROMONE_MATRIX_UPDATE_MACROS_SVH
`ifndef SYNTHESIS
`define PMU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pmu assertion failed");
`define PMU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pmu assertion failed");
`else
`define PMU_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define PMU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> src/pmu_pkg.sv
// Types and constants of the pheromone matrix update block.
package pmu_pkg;

  localparam int CITIES_DEFAULT = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] KIND_INIT    = 2'd0;
  localparam logic [1:0] KIND_DEPOSIT = 2'd1;
  localparam logic [1:0] KIND_SWEEP   = 2'd2;
  localparam logic [1:0] KIND_READ    = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  localparam logic [1:0] CFG_EVAPORATION      = 2'd0;
  localparam logic [1:0] CFG_DISTANCE_WEIGHT  = 2'd1;
  localparam logic [1:0] CFG_DEPOSIT_CONSTANT = 2'd2;
  localparam logic [1:0] CFG_INITIAL_TRAIL    = 2'd3;

  localparam logic [15:0] EVAPORATION_RESET      = 16'd32768;
  localparam logic [16:0] DISTANCE_WEIGHT_RESET  = 17'd32768;
  localparam logic [15:0] DEPOSIT_CONSTANT_RESET = 16'd100;
  localparam logic [31:0] INITIAL_TRAIL_RESET    = 32'd65536;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
  localparam logic [16:0] WEIGHT_ONE = 17'h1_0000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  from_city;
    logic [4:0]  to_city;
    logic [23:0] tour_length;
    logic [23:0] time_cost;
    logic        use_time_weight;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        in_range;
    logic [4:0]  from_city;
    logic [4:0]  to_city;
    logic [23:0] tour_length;
    logic [23:0] time_cost;
    logic        use_time_weight;
  } pmu_cmd_t;

  typedef struct packed {
    logic [15:0] evaporation;
    logic [16:0] distance_weight;
    logic [15:0] deposit_constant;
    logic [31:0] initial_trail;
  } pmu_cfg_t;

endpackage

>>> src/pmu_front.sv
// Input stage that accepts transactions and classifies them into commands.
module pmu_front #(
  parameter int CITIES = pmu_pkg::CITIES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pmu_pkg::in_item_t  in_data,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output pmu_pkg::pmu_cmd_t  cmd
);

  logic              v_r;
  pmu_pkg::pmu_cmd_t cmd_r;

  assign in_ready  = !v_r || cmd_ready;
  assign cmd_valid = v_r;
  assign cmd       = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r.kind            <= in_data.kind;
      cmd_r.in_range        <= (32'(in_data.from_city) < 32'(CITIES)) &&
                               (32'(in_data.to_city) < 32'(CITIES));
      cmd_r.from_city       <= in_data.from_city;
      cmd_r.to_city         <= in_data.to_city;
      cmd_r.tour_length     <= in_data.tour_length;
      cmd_r.time_cost       <= in_data.time_cost;
      cmd_r.use_time_weight <= in_data.use_time_weight;
    end
  end

endmodule

>>> src/pmu_queue.sv
// Short command queue between the front and back parts.
`include "pheromone_matrix_update_macros.svh"
module pmu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  pmu_pkg::pmu_cmd_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output pmu_pkg::pmu_cmd_t pop_data
);

  localparam int DEPTH = pmu_pkg::QUEUE_DEPTH;
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pmu_pkg::pmu_cmd_t slot_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [CW-1:0]     cnt_r;
  logic              push;
  logic              pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  `PMU_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(DEPTH))
  `PMU_ASSERT_NEXT(a_cnt_grow, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 1'b1)

endmodule

>>> src/pmu_back.sv
// Back part: divider, mixing, matrix memories and result register.
`include "pheromone_matrix_update_macros.svh"
module pmu_back #(
  parameter int CITIES = pmu_pkg::CITIES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pmu_pkg::pmu_cfg_t  cfg,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  pmu_pkg::pmu_cmd_t  cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output pmu_pkg::out_item_t out_data
);

  localparam int N  = CITIES * CITIES;
  localparam int AW = $clog2(N);
  localparam logic [AW-1:0] LAST = AW'(N - 1);
  localparam logic [5:0] DIV_LAST = 6'd47;

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_INIT = 5'd2;
  localparam logic [4:0] S_DIV1 = 5'd3;
  localparam logic [4:0] S_DIV2 = 5'd4;
  localparam logic [4:0] S_MUL1 = 5'd5;
  localparam logic [4:0] S_MUL2 = 5'd6;
  localparam logic [4:0] S_MIX  = 5'd7;
  localparam logic [4:0] S_RDA  = 5'd8;
  localparam logic [4:0] S_WRA  = 5'd9;
  localparam logic [4:0] S_RDB  = 5'd10;
  localparam logic [4:0] S_WRB  = 5'd11;
  localparam logic [4:0] S_SWP  = 5'd12;
  localparam logic [4:0] S_SWD  = 5'd13;
  localparam logic [4:0] S_RD   = 5'd14;
  localparam logic [4:0] S_RDO  = 5'd15;
  localparam logic [4:0] S_DONE = 5'd16;

  logic [4:0]         state_r, state_nxt;
  logic [AW-1:0]      idx_r, widx_r;
  logic               sw_v_r;
  pmu_pkg::pmu_cmd_t  cmd_r;
  logic [47:0]        num_r;
  logic [24:0]        rem_r;
  logic [31:0]        quo_r;
  logic [23:0]        dvs_r;
  logic [5:0]         cnt_r;
  logic [31:0]        lterm_r, tterm_r, amount_r;
  logic [48:0]        prod1_r, prod2_r;
  logic               zero_r, sat_r;
  logic [31:0]        res_value_r;
  logic [1:0]         res_status_r;
  logic               out_valid_r;
  pmu_pkg::out_item_t out_data_r;

  logic [31:0] trail_mem [N];
  logic [31:0] pend_mem [N];
  logic [31:0] t_rdata_r, p_rdata_r;
  logic        t_we, p_we;
  logic [AW-1:0] w_addr, r_addr;
  logic [31:0] t_wdata, p_wdata;

  logic [AW-1:0] addr_a, addr_b;
  logic [24:0]   trial, rem_step;
  logic          ge;
  logic [31:0]   quo_step, term_val;
  logic          div_last, out_free;
  logic [16:0]   q_eff, q_cmp;
  logic [48:0]   mix_sum;
  logic [47:0]   kept_prod;
  logic [32:0]   sw_sum, dep_sum;
  logic [31:0]   dep_sat;

  assign addr_a = AW'(32'(cmd_r.from_city) * 32'(CITIES) + 32'(cmd_r.to_city));
  assign addr_b = AW'(32'(cmd_r.to_city) * 32'(CITIES) + 32'(cmd_r.from_city));

  assign trial    = {rem_r[23:0], num_r[47]};
  assign ge       = (trial >= {1'b0, dvs_r});
  assign rem_step = ge ? (trial - {1'b0, dvs_r}) : trial;
  assign quo_step = {quo_r[30:0], ge};
  assign div_last = (cnt_r == DIV_LAST);
  assign term_val = (dvs_r == '0) ? pmu_pkg::SAT32 : quo_step;

  assign q_eff   = (cfg.distance_weight > pmu_pkg::WEIGHT_ONE) ? pmu_pkg::WEIGHT_ONE
                                                               : cfg.distance_weight;
  assign q_cmp   = pmu_pkg::WEIGHT_ONE - q_eff;
  assign mix_sum = prod1_r + prod2_r;

  assign kept_prod = cfg.evaporation * t_rdata_r;
  assign sw_sum    = {1'b0, kept_prod[47:16]} + {1'b0, p_rdata_r};
  assign dep_sum   = {1'b0, p_rdata_r} + {1'b0, amount_r};
  assign dep_sat   = dep_sum[32] ? pmu_pkg::SAT32 : dep_sum[31:0];

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    cmd_ready = 1'b0;
    t_we      = 1'b0;
    p_we      = 1'b0;
    w_addr    = idx_r;
    r_addr    = idx_r;
    t_wdata   = '0;
    p_wdata   = '0;
    if (sw_v_r) begin
      t_we    = 1'b1;
      p_we    = 1'b1;
      w_addr  = widx_r;
      t_wdata = sw_sum[32] ? pmu_pkg::SAT32 : sw_sum[31:0];
    end
    unique case (state_r)
      S_CLR: begin
        t_we    = 1'b1;
        p_we    = 1'b1;
        t_wdata = pmu_pkg::INITIAL_TRAIL_RESET;
        if (idx_r == LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          unique case (cmd.kind)
            pmu_pkg::KIND_INIT:    state_nxt = S_INIT;
            pmu_pkg::KIND_DEPOSIT: state_nxt = cmd.in_range ? S_DIV1 : S_DONE;
            pmu_pkg::KIND_SWEEP:   state_nxt = S_SWP;
            pmu_pkg::KIND_READ:    state_nxt = cmd.in_range ? S_RD : S_DONE;
            default:               state_nxt = S_DONE;
          endcase
        end
      end
      S_INIT: begin
        t_we    = 1'b1;
        p_we    = 1'b1;
        t_wdata = cfg.initial_trail;
        if (idx_r == LAST) state_nxt = S_DONE;
      end
      S_DIV1: begin
        if (div_last) state_nxt = cmd_r.use_time_weight ? S_DIV2 : S_RDA;
      end
      S_DIV2: begin
        if (div_last) state_nxt = S_MUL1;
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_MIX;
      S_MIX:  state_nxt = S_RDA;
      S_RDA: begin
        r_addr    = addr_a;
        state_nxt = S_WRA;
      end
      S_WRA: begin
        p_we      = 1'b1;
        w_addr    = addr_a;
        p_wdata   = dep_sat;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        r_addr    = addr_b;
        state_nxt = S_WRB;
      end
      S_WRB: begin
        p_we      = 1'b1;
        w_addr    = addr_b;
        p_wdata   = dep_sat;
        state_nxt = S_DONE;
      end
      S_SWP: begin
        if (idx_r == LAST) state_nxt = S_SWD;
      end
      S_SWD: state_nxt = S_DONE;
      S_RD: begin
        r_addr    = addr_a;
        state_nxt = S_RDO;
      end
      S_RDO: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      sw_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sw_v_r  <= (state_r == S_SWP);
      if (state_r == S_CLR || state_r == S_INIT || state_r == S_SWP) begin
        idx_r <= (idx_r == LAST) ? '0 : idx_r + 1'b1;
      end else begin
        idx_r <= '0;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    widx_r <= idx_r;
    if (state_r == S_DONE && out_free) begin
      out_data_r.value  <= res_value_r;
      out_data_r.status <= res_status_r;
    end
    if (sw_v_r && sw_sum[32]) begin
      sat_r <= 1'b1;
    end
    unique case (state_r)
      S_IDLE: begin
        cmd_r        <= cmd;
        num_r        <= {16'h0000, cfg.deposit_constant, 16'h0000};
        rem_r        <= '0;
        quo_r        <= '0;
        cnt_r        <= '0;
        dvs_r        <= cmd.tour_length;
        zero_r       <= 1'b0;
        sat_r        <= 1'b0;
        res_value_r  <= '0;
        res_status_r <= pmu_pkg::STATUS_OK;
      end
      S_DIV1, S_DIV2: begin
        if (div_last) begin
          if (dvs_r == '0) zero_r <= 1'b1;
          if (state_r == S_DIV1) begin
            lterm_r  <= term_val;
            amount_r <= term_val;
          end else begin
            tterm_r <= term_val;
          end
          num_r <= {16'h0000, cfg.deposit_constant, 16'h0000};
          rem_r <= '0;
          quo_r <= '0;
          cnt_r <= '0;
          dvs_r <= cmd_r.time_cost;
        end else begin
          num_r <= {num_r[46:0], 1'b0};
          rem_r <= rem_step;
          quo_r <= quo_step;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      S_MUL1: prod1_r <= q_eff * lterm_r;
      S_MUL2: prod2_r <= q_cmp * tterm_r;
      S_MIX:  amount_r <= mix_sum[47:16];
      S_WRA: begin
        if (dep_sum[32]) sat_r <= 1'b1;
      end
      S_WRB: begin
        res_status_r <= zero_r ? pmu_pkg::STATUS_ZERO :
                        (sat_r || dep_sum[32]) ? pmu_pkg::STATUS_SAT : pmu_pkg::STATUS_OK;
      end
      S_SWD: begin
        res_status_r <= (sat_r || sw_sum[32]) ? pmu_pkg::STATUS_SAT : pmu_pkg::STATUS_OK;
      end
      S_RDO: res_value_r <= t_rdata_r;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (t_we) trail_mem[w_addr] <= t_wdata;
    t_rdata_r <= trail_mem[r_addr];
  end

  always_ff @(posedge clk) begin
    if (p_we) pend_mem[w_addr] <= p_wdata;
    p_rdata_r <= pend_mem[r_addr];
  end

  `PMU_ASSERT_NEXT(a_hold_result, clk, rst_n,
                   state_r == S_DONE && out_valid_r && !out_ready, state_r == S_DONE)
  `PMU_ASSERT_NOW(a_deposit_trail, clk, rst_n,
                  state_r == S_WRA || state_r == S_WRB, !t_we)
  `PMU_ASSERT_NOW(a_sweep_drain, clk, rst_n, sw_v_r,
                  state_r == S_SWP || state_r == S_SWD)

endmodule

>>> src/pheromone_matrix_update.sv
// Pheromone matrix update block: configuration registers, front, queue and back.
//
// Items arrive on the in_ channel as valid/ready transactions and each yields one
// result transaction on the out_ channel, in order. Configuration writes arrive on
// the cfg_ channel (index 0 evaporation, 1 distance weight, 2 deposit constant,
// 3 initial trail) and are always accepted; write them only while the block is idle.
// Items are worked one at a time by the back part; the front register and a
// two-entry queue take further items meanwhile.
// A deposit runs a 48-step restoring divider, twice with time weighting (two
// divisions); init and evaporate walk the whole matrix, one matrix entry per cycle
// through the single write port of the trail and deposit memories.
// After reset the block runs a clearing pass over all CITIES*CITIES entries, setting
// every trail entry to 1.0 and every deposit to zero; the back part takes no items
// during it, and the front and queue hold up to three. When the receiver stalls,
// the result is held in the output register and the back part waits; the front
// keeps accepting until the queue fills.
module pheromone_matrix_update #(
  parameter int CITIES = pmu_pkg::CITIES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pmu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pmu_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  pmu_pkg::pmu_cfg_t cfg_r;
  pmu_pkg::pmu_cmd_t front_cmd, queue_cmd;
  logic              front_valid, front_ready, queue_valid, queue_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.evaporation      <= pmu_pkg::EVAPORATION_RESET;
      cfg_r.distance_weight  <= pmu_pkg::DISTANCE_WEIGHT_RESET;
      cfg_r.deposit_constant <= pmu_pkg::DEPOSIT_CONSTANT_RESET;
      cfg_r.initial_trail    <= pmu_pkg::INITIAL_TRAIL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pmu_pkg::CFG_EVAPORATION:      cfg_r.evaporation      <= cfg_data[15:0];
        pmu_pkg::CFG_DISTANCE_WEIGHT:  cfg_r.distance_weight  <= cfg_data[16:0];
        pmu_pkg::CFG_DEPOSIT_CONSTANT: cfg_r.deposit_constant <= cfg_data[15:0];
        pmu_pkg::CFG_INITIAL_TRAIL:    cfg_r.initial_trail    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pmu_front #(.CITIES(CITIES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  pmu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cmd),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_data   (queue_cmd)
  );

  pmu_back #(.CITIES(CITIES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (queue_valid),
    .cmd_ready (queue_ready),
    .cmd       (queue_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
